### src/x86dec_pkg.sv
// ----------------------------------------------------------------------------
// x86dec_pkg
// Shared types, constants and helper functions for the 16-bit x86
// mov/add/sub/cmp instruction decoder.
// ----------------------------------------------------------------------------
package x86dec_pkg;

  // longest handled instruction: opcode, mod-reg-r/m, two disp, two imm
  localparam int MaxInstrBytes = 6;
  // entries in the queue between byte collection and decoding
  localparam int QueueDepth    = 2;

  // operation codes
  localparam logic [1:0] OpMov = 2'd0;
  localparam logic [1:0] OpAdd = 2'd1;
  localparam logic [1:0] OpSub = 2'd2;
  localparam logic [1:0] OpCmp = 2'd3;

  // instruction forms
  localparam logic [2:0] FormRmReg    = 3'd0;
  localparam logic [2:0] FormImmToRm  = 3'd1;
  localparam logic [2:0] FormImmToAcc = 3'd2;
  localparam logic [2:0] FormImmToReg = 3'd3;
  localparam logic [2:0] FormMemToAcc = 3'd4;
  localparam logic [2:0] FormAccToMem = 3'd5;

  // r/m code for a direct address
  localparam logic [2:0] RmDirect = 3'd6;

  // opcode classes
  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_MOVRM  = 3'd1,
    KIND_MOVIMM = 3'd2,
    KIND_GROUP  = 3'd3,
    KIND_ARITH  = 3'd4,
    KIND_ACCIMM = 3'd5,
    KIND_REGIMM = 3'd6,
    KIND_ACCMEM = 3'd7
  } kind_t;

  // one collected instruction, handed from front to back
  typedef struct packed {
    logic [MaxInstrBytes-1:0][7:0] instr_bytes;
    kind_t                         kind;
    logic [2:0]                    len;
  } instr_t;

  // one decoded record
  typedef struct packed {
    logic [1:0]         operation;
    logic [2:0]         form;
    logic               wide;
    logic               to_register;
    logic [1:0]         mode_field;
    logic [2:0]         reg_field;
    logic [2:0]         rm_field;
    logic signed [15:0] displacement;
    logic signed [15:0] immediate;
    logic [2:0]         length;
    logic               unknown;
  } rec_t;

  // opcode class from the first byte
  function automatic kind_t classify(input logic [7:0] b);
    kind_t k;
    k = KIND_NONE;
    if (b[7:2] == 6'h22) begin
      k = KIND_MOVRM;
    end else if (b[7:1] == 7'h63) begin
      k = KIND_MOVIMM;
    end else if (b[7:2] == 6'h20) begin
      k = KIND_GROUP;
    end else if (b[7:4] == 4'hB) begin
      k = KIND_REGIMM;
    end else if (b[7:1] == 7'h50 || b[7:1] == 7'h51) begin
      k = KIND_ACCMEM;
    end else if (b[7:6] == 2'b00 && b[2:0] <= 3'd5) begin
      if (b[5:3] == 3'd0 || b[5:3] == 3'd5 || b[5:3] == 3'd7) begin
        k = (b[2:0] < 3'd4) ? KIND_ARITH : KIND_ACCIMM;
      end
    end
    return k;
  endfunction

  // displacement bytes that follow the addressing byte
  function automatic logic [1:0] disp_bytes(input logic [7:0] modrm);
    logic [1:0] n;
    case (modrm[7:6])
      2'd0:    n = (modrm[2:0] == RmDirect) ? 2'd2 : 2'd0;
      2'd1:    n = 2'd1;
      2'd2:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // immediate bytes for the immediate-to-r/m forms
  function automatic logic [1:0] imm_bytes(input kind_t k, input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (k == KIND_MOVIMM) begin
      n = b[0] ? 2'd2 : 2'd1;
    end else if (k == KIND_GROUP) begin
      n = (b == 8'h81) ? 2'd2 : 2'd1;
    end
    return n;
  endfunction

  // arithmetic operation from a three-bit group code
  function automatic logic [1:0] arith_op(input logic [2:0] g);
    logic [1:0] op;
    case (g)
      3'd0:    op = OpAdd;
      3'd5:    op = OpSub;
      3'd7:    op = OpCmp;
      default: op = OpMov;
    endcase
    return op;
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

endpackage

### src/x86dec_front.sv
// ----------------------------------------------------------------------------
// x86dec_front
// Collects code bytes, classifies the opcode, works out the instruction
// length and pushes each complete instruction into the queue.
// ----------------------------------------------------------------------------
module x86dec_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_code_byte,
  input  logic                q_full,
  output logic                q_push,
  output x86dec_pkg::instr_t  q_entry
);

  logic [7:0]                  held_r [x86dec_pkg::MaxInstrBytes];
  logic [2:0]                  taken_r, taken_nxt;
  logic [2:0]                  needed_r, needed_nxt;
  logic [7:0]                  first_byte;
  logic [7:0]                  modrm_byte;
  x86dec_pkg::kind_t           kind;
  logic [2:0]                  len_calc;
  logic [2:0]                  needed;
  logic [2:0]                  taken_inc;
  logic                        done;
  logic                        accept;
  logic [x86dec_pkg::MaxInstrBytes-1:0][7:0] cur_bytes;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // classify and size the instruction including the byte now arriving
  always_comb begin
    first_byte = (taken_r == 3'd0) ? in_code_byte : held_r[0];
    modrm_byte = (taken_r == 3'd1) ? in_code_byte : held_r[1];
    kind       = x86dec_pkg::classify(first_byte);
    unique case (kind)
      x86dec_pkg::KIND_ACCIMM: len_calc = first_byte[0] ? 3'd3 : 3'd2;
      x86dec_pkg::KIND_REGIMM: len_calc = first_byte[3] ? 3'd3 : 3'd2;
      x86dec_pkg::KIND_ACCMEM: len_calc = 3'd3;
      x86dec_pkg::KIND_MOVRM, x86dec_pkg::KIND_MOVIMM,
      x86dec_pkg::KIND_GROUP, x86dec_pkg::KIND_ARITH: begin
        if (taken_r == 3'd0) begin
          len_calc = 3'd0;
        end else begin
          len_calc = 3'd2 + {1'b0, x86dec_pkg::disp_bytes(modrm_byte)}
                   + {1'b0, x86dec_pkg::imm_bytes(kind, first_byte)};
        end
      end
      default: len_calc = 3'd1;
    endcase
    needed    = (needed_r != 3'd0) ? needed_r : len_calc;
    taken_inc = taken_r + 3'd1;
    done      = (needed != 3'd0) && (taken_inc >= needed);
    for (int i = 0; i < x86dec_pkg::MaxInstrBytes; i++) begin
      cur_bytes[i] = (taken_r == 3'(i)) ? in_code_byte : held_r[i];
    end
  end

  // queue entry for a finished instruction
  assign q_push              = accept && done;
  assign q_entry.instr_bytes = cur_bytes;
  assign q_entry.kind        = kind;
  assign q_entry.len         = needed;

  // next counter values
  always_comb begin
    taken_nxt  = taken_r;
    needed_nxt = needed_r;
    if (accept) begin
      if (done) begin
        taken_nxt  = 3'd0;
        needed_nxt = 3'd0;
      end else begin
        taken_nxt  = taken_inc;
        needed_nxt = needed;
      end
    end
  end

  // byte store
  always_ff @(posedge clk) begin
    if (accept) begin
      held_r[taken_r] <= in_code_byte;
    end
  end

  // collection counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r  <= 3'd0;
      needed_r <= 3'd0;
    end else begin
      taken_r  <= taken_nxt;
      needed_r <= needed_nxt;
    end
  end

endmodule

### src/x86dec_queue.sv
// ----------------------------------------------------------------------------
// x86dec_queue
// Small queue of collected instructions between the front and the back.
// ----------------------------------------------------------------------------
module x86dec_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  x86dec_pkg::instr_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output x86dec_pkg::instr_t head
);

  localparam int PtrW = $clog2(x86dec_pkg::QueueDepth);
  localparam int CntW = $clog2(x86dec_pkg::QueueDepth + 1);

  x86dec_pkg::instr_t  slot_r [x86dec_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;

  assign full      = (count_r == CntW'(x86dec_pkg::QueueDepth));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(x86dec_pkg::QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(x86dec_pkg::QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/x86dec_back.sv
// ----------------------------------------------------------------------------
// x86dec_back
// Decodes the instruction at the head of the queue into one record and
// holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module x86dec_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  x86dec_pkg::instr_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output x86dec_pkg::rec_t   out_rec
);

  x86dec_pkg::rec_t   rec;
  x86dec_pkg::rec_t   rec_r;
  logic               valid_r, valid_nxt;
  logic [7:0]         b0;
  logic [7:0]         modrm;
  logic [1:0]         dl;
  logic [1:0]         il;
  logic [7:0]         imm_lo;
  logic [7:0]         imm_hi;
  logic [15:0]        word1;

  assign out_valid = valid_r;
  assign out_rec   = rec_r;
  assign q_pop     = q_not_empty && (!valid_r || !out_stall);

  // record decode
  always_comb begin
    b0     = q_head.instr_bytes[0];
    modrm  = q_head.instr_bytes[1];
    dl     = x86dec_pkg::disp_bytes(modrm);
    il     = x86dec_pkg::imm_bytes(q_head.kind, b0);
    word1  = {q_head.instr_bytes[2], q_head.instr_bytes[1]};
    // immediate follows the displacement
    case (dl)
      2'd1: begin
        imm_lo = q_head.instr_bytes[3];
        imm_hi = q_head.instr_bytes[4];
      end
      2'd2: begin
        imm_lo = q_head.instr_bytes[4];
        imm_hi = q_head.instr_bytes[5];
      end
      default: begin
        imm_lo = q_head.instr_bytes[2];
        imm_hi = q_head.instr_bytes[3];
      end
    endcase

    rec        = '0;
    rec.length = q_head.len;
    unique case (q_head.kind)
      x86dec_pkg::KIND_MOVRM, x86dec_pkg::KIND_ARITH,
      x86dec_pkg::KIND_MOVIMM, x86dec_pkg::KIND_GROUP: begin
        rec.mode_field = modrm[7:6];
        rec.reg_field  = modrm[5:3];
        rec.rm_field   = modrm[2:0];
        rec.wide       = b0[0];
        if (dl == 2'd1) begin
          rec.displacement = x86dec_pkg::sext8(q_head.instr_bytes[2]);
        end else if (dl == 2'd2) begin
          rec.displacement = {q_head.instr_bytes[3], q_head.instr_bytes[2]};
        end
        if (q_head.kind == x86dec_pkg::KIND_MOVRM || q_head.kind == x86dec_pkg::KIND_ARITH) begin
          rec.operation   = (q_head.kind == x86dec_pkg::KIND_ARITH) ?
                            x86dec_pkg::arith_op(b0[5:3]) : x86dec_pkg::OpMov;
          rec.form        = x86dec_pkg::FormRmReg;
          rec.to_register = b0[1];
        end else begin
          rec.form      = x86dec_pkg::FormImmToRm;
          rec.immediate = (il == 2'd2) ? {imm_hi, imm_lo} : x86dec_pkg::sext8(imm_lo);
          if (q_head.kind == x86dec_pkg::KIND_GROUP) begin
            if (modrm[5:3] != 3'd0 && modrm[5:3] != 3'd5 && modrm[5:3] != 3'd7) begin
              // group code other than add, sub or cmp
              rec         = '0;
              rec.length  = q_head.len;
              rec.unknown = 1'b1;
            end else begin
              rec.operation = x86dec_pkg::arith_op(modrm[5:3]);
            end
          end
        end
      end
      x86dec_pkg::KIND_ACCIMM: begin
        rec.operation   = x86dec_pkg::arith_op(b0[5:3]);
        rec.form        = x86dec_pkg::FormImmToAcc;
        rec.wide        = b0[0];
        rec.to_register = 1'b1;
        rec.immediate   = b0[0] ? word1 : x86dec_pkg::sext8(q_head.instr_bytes[1]);
      end
      x86dec_pkg::KIND_REGIMM: begin
        rec.form        = x86dec_pkg::FormImmToReg;
        rec.wide        = b0[3];
        rec.to_register = 1'b1;
        rec.reg_field   = b0[2:0];
        rec.immediate   = b0[3] ? word1 : x86dec_pkg::sext8(q_head.instr_bytes[1]);
      end
      x86dec_pkg::KIND_ACCMEM: begin
        rec.form         = b0[1] ? x86dec_pkg::FormAccToMem : x86dec_pkg::FormMemToAcc;
        rec.wide         = b0[0];
        rec.to_register  = !b0[1];
        rec.rm_field     = x86dec_pkg::RmDirect;
        rec.displacement = word1;
      end
      default: begin
        rec.length  = 3'd1;
        rec.unknown = 1'b1;
      end
    endcase
  end

  // output valid
  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  // output record register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

### src/x86_16_mov_alu_instruction_decoder.sv
// ----------------------------------------------------------------------------
// x86_16_mov_alu_instruction_decoder
// Byte-stream decoder for the 16-bit x86 mov, add, sub and cmp forms.
// ----------------------------------------------------------------------------
//   channel   direction  handshake          payload
//   in_       input      in_valid/in_stall  in_code_byte
//   out_      output     out_valid/out_stall decoded record, one per instruction
//
// One code byte is taken per cycle while in_stall is low; each instruction is
// queued with its last byte, then decoded and its record registered.
// The front collects bytes into a six-byte store and a two-entry queue feeds
// the decode stage, so the front keeps taking bytes while a record waits.
// in_stall rises only when the queue is full behind a stalled output.
// Synchronous reset clears the byte counters, the queue and the output valid.
// ----------------------------------------------------------------------------
module x86_16_mov_alu_instruction_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_code_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_operation,
  output logic [2:0]         out_form,
  output logic               out_wide,
  output logic               out_to_register,
  output logic [1:0]         out_mode_field,
  output logic [2:0]         out_reg_field,
  output logic [2:0]         out_rm_field,
  output logic signed [15:0] out_displacement,
  output logic signed [15:0] out_immediate,
  output logic [2:0]         out_length,
  output logic               out_unknown
);

  x86dec_pkg::instr_t push_entry;
  x86dec_pkg::instr_t head;
  x86dec_pkg::rec_t   rec;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_not_empty;

  // byte collection
  x86dec_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_code_byte (in_code_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  // instruction queue
  x86dec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  // decode and output register
  x86dec_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_rec     (rec)
  );

  assign out_operation    = rec.operation;
  assign out_form         = rec.form;
  assign out_wide         = rec.wide;
  assign out_to_register  = rec.to_register;
  assign out_mode_field   = rec.mode_field;
  assign out_reg_field    = rec.reg_field;
  assign out_rm_field     = rec.rm_field;
  assign out_displacement = rec.displacement;
  assign out_immediate    = rec.immediate;
  assign out_length       = rec.length;
  assign out_unknown      = rec.unknown;

endmodule

### dv/tb_x86_16_mov_alu_instruction_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_x86_16_mov_alu_instruction_decoder
// Feeds a code byte stream of mov/add/sub/cmp instructions into the decoder,
// with random gaps on the input and random stalls on the output. A scoreboard
// predicts one decoded record per completed instruction and compares every
// accepted record field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_x86_16_mov_alu_instruction_decoder;

  // decoder model plus queue of predicted records
  class decode_checker;
    logic [7:0]         held [x86dec_pkg::MaxInstrBytes];
    int unsigned        taken;
    int unsigned        needed;
    x86dec_pkg::rec_t   expected_records [$];
    int                 errors;

    function new();
      taken  = 0;
      needed = 0;
      errors = 0;
      foreach (held[i]) held[i] = 8'h00;
    endfunction

    // opcode class of a first byte
    function x86dec_pkg::kind_t opcode_kind(logic [7:0] b);
      if (b[7:2] == 6'b100010) return x86dec_pkg::KIND_MOVRM;
      if (b[7:1] == 7'b1100011) return x86dec_pkg::KIND_MOVIMM;
      if (b[7:2] == 6'b100000) return x86dec_pkg::KIND_GROUP;
      if (b[7:4] == 4'b1011) return x86dec_pkg::KIND_REGIMM;
      if (b[7:2] == 6'b101000) return x86dec_pkg::KIND_ACCMEM;
      if (b[7:6] == 2'b00 && b[2:0] <= 3'd5 &&
          (b[5:3] == 3'd0 || b[5:3] == 3'd5 || b[5:3] == 3'd7)) begin
        return (b[2:0] < 3'd4) ? x86dec_pkg::KIND_ARITH : x86dec_pkg::KIND_ACCIMM;
      end
      return x86dec_pkg::KIND_NONE;
    endfunction

    function logic [1:0] alu_op(logic [2:0] g);
      case (g)
        3'd0:    return x86dec_pkg::OpAdd;
        3'd5:    return x86dec_pkg::OpSub;
        3'd7:    return x86dec_pkg::OpCmp;
        default: return x86dec_pkg::OpMov;
      endcase
    endfunction

    function int unsigned disp_len(logic [7:0] modrm);
      case (modrm[7:6])
        2'd0:    return (modrm[2:0] == x86dec_pkg::RmDirect) ? 2 : 0;
        2'd1:    return 1;
        2'd2:    return 2;
        default: return 0;
      endcase
    endfunction

    function int unsigned imm_len(x86dec_pkg::kind_t k, logic [7:0] b);
      if (k == x86dec_pkg::KIND_MOVIMM) return b[0] ? 2 : 1;
      if (k == x86dec_pkg::KIND_GROUP) return (b == 8'h81) ? 2 : 1;
      return 0;
    endfunction

    // instruction length, 0 while the addressing byte is still missing
    function int unsigned length_of(x86dec_pkg::kind_t k);
      case (k)
        x86dec_pkg::KIND_ACCIMM: return held[0][0] ? 3 : 2;
        x86dec_pkg::KIND_REGIMM: return held[0][3] ? 3 : 2;
        x86dec_pkg::KIND_ACCMEM: return 3;
        x86dec_pkg::KIND_MOVRM, x86dec_pkg::KIND_MOVIMM,
        x86dec_pkg::KIND_GROUP, x86dec_pkg::KIND_ARITH: begin
          if (taken < 2) return 0;
          return 2 + disp_len(held[1]) + imm_len(k, held[0]);
        end
        default: return 1;
      endcase
    endfunction

    function logic [15:0] sext_byte(logic [7:0] v);
      return {{8{v[7]}}, v};
    endfunction

    function logic [15:0] word_from(int unsigned p);
      return {held[p+1], held[p]};
    endfunction

    // decoded record of the collected instruction
    function x86dec_pkg::rec_t predict_record(x86dec_pkg::kind_t k, int unsigned len);
      x86dec_pkg::rec_t r;
      logic [7:0]       b;
      logic [7:0]       m;
      int unsigned      dl;
      int unsigned      p;
      r = '0;
      b = held[0];
      r.length = len[2:0];
      case (k)
        x86dec_pkg::KIND_MOVRM, x86dec_pkg::KIND_ARITH,
        x86dec_pkg::KIND_MOVIMM, x86dec_pkg::KIND_GROUP: begin
          m = held[1];
          dl = disp_len(m);
          p = 2 + dl;
          r.mode_field = m[7:6];
          r.reg_field  = m[5:3];
          r.rm_field   = m[2:0];
          r.wide       = b[0];
          if (dl == 1) r.displacement = sext_byte(held[2]);
          else if (dl == 2) r.displacement = word_from(2);
          if (k == x86dec_pkg::KIND_MOVRM || k == x86dec_pkg::KIND_ARITH) begin
            r.operation   = (k == x86dec_pkg::KIND_ARITH) ? alu_op(b[5:3]) :
                            x86dec_pkg::OpMov;
            r.form        = x86dec_pkg::FormRmReg;
            r.to_register = b[1];
          end else begin
            r.form = x86dec_pkg::FormImmToRm;
            r.immediate = (imm_len(k, b) == 2) ? word_from(p) : sext_byte(held[p]);
            if (k == x86dec_pkg::KIND_GROUP) begin
              if (m[5:3] != 3'd0 && m[5:3] != 3'd5 && m[5:3] != 3'd7) begin
                // group entry that is not add, sub or cmp
                r = '0;
                r.length  = len[2:0];
                r.unknown = 1'b1;
              end else begin
                r.operation = alu_op(m[5:3]);
              end
            end
          end
        end
        x86dec_pkg::KIND_ACCIMM: begin
          r.operation   = alu_op(b[5:3]);
          r.form        = x86dec_pkg::FormImmToAcc;
          r.wide        = b[0];
          r.to_register = 1'b1;
          r.immediate   = b[0] ? word_from(1) : sext_byte(held[1]);
        end
        x86dec_pkg::KIND_REGIMM: begin
          r.form        = x86dec_pkg::FormImmToReg;
          r.wide        = b[3];
          r.to_register = 1'b1;
          r.reg_field   = b[2:0];
          r.immediate   = b[3] ? word_from(1) : sext_byte(held[1]);
        end
        x86dec_pkg::KIND_ACCMEM: begin
          r.form         = b[1] ? x86dec_pkg::FormAccToMem : x86dec_pkg::FormMemToAcc;
          r.wide         = b[0];
          r.to_register  = ~b[1];
          r.rm_field     = x86dec_pkg::RmDirect;
          r.displacement = word_from(1);
        end
        default: begin
          r.length  = 3'd1;
          r.unknown = 1'b1;
        end
      endcase
      return r;
    endfunction

    // accepted input transaction
    function void take_code_byte(logic [7:0] b);
      x86dec_pkg::kind_t k;
      if (taken >= x86dec_pkg::MaxInstrBytes) begin
        taken  = 0;
        needed = 0;
      end
      held[taken] = b;
      taken++;
      k = opcode_kind(held[0]);
      if (needed == 0) needed = length_of(k);
      if (needed != 0 && taken >= needed) begin
        expected_records.push_back(predict_record(k, needed));
        taken  = 0;
        needed = 0;
      end
    endfunction

    function int pending();
      return expected_records.size();
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      end
    endtask

    // accepted output transaction against the oldest prediction
    task check_record(x86dec_pkg::rec_t got);
      x86dec_pkg::rec_t want;
      if (expected_records.size() == 0) begin
        report_mismatch("record with no instruction pending");
      end else begin
        want = expected_records.pop_front();
        compare_field("operation", got.operation, want.operation);
        compare_field("form", got.form, want.form);
        compare_field("wide", got.wide, want.wide);
        compare_field("to_register", got.to_register, want.to_register);
        compare_field("mode_field", got.mode_field, want.mode_field);
        compare_field("reg_field", got.reg_field, want.reg_field);
        compare_field("rm_field", got.rm_field, want.rm_field);
        compare_field("displacement", got.displacement, want.displacement);
        compare_field("immediate", got.immediate, want.immediate);
        compare_field("length", got.length, want.length);
        compare_field("unknown", got.unknown, want.unknown);
      end
    endtask

    task report_leftover();
      if (expected_records.size() != 0) begin
        report_mismatch($sformatf("%0d records never arrived", expected_records.size()));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_code_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_operation;
  logic [2:0]         out_form;
  logic               out_wide;
  logic               out_to_register;
  logic [1:0]         out_mode_field;
  logic [2:0]         out_reg_field;
  logic [2:0]         out_rm_field;
  logic signed [15:0] out_displacement;
  logic signed [15:0] out_immediate;
  logic [2:0]         out_length;
  logic               out_unknown;

  decode_checker chk;
  logic [7:0]    code_stream [$];
  int            records_seen;
  logic          receiver_holding;
  logic          long_hold_done;

  localparam int StreamBytes = 1000;
  localparam int PauseIndex  = 700;
  localparam int LongHold    = 80;

  x86_16_mov_alu_instruction_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_byte     (in_code_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_operation    (out_operation),
    .out_form         (out_form),
    .out_wide         (out_wide),
    .out_to_register  (out_to_register),
    .out_mode_field   (out_mode_field),
    .out_reg_field    (out_reg_field),
    .out_rm_field     (out_rm_field),
    .out_displacement (out_displacement),
    .out_immediate    (out_immediate),
    .out_length       (out_length),
    .out_unknown      (out_unknown)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // one random instruction, sometimes cut short or replaced by a stray byte
  task automatic append_instruction();
    logic [7:0]        inst [$];
    logic [7:0]        op;
    logic [7:0]        modrm;
    logic [2:0]        g;
    x86dec_pkg::kind_t k;
    int unsigned       extra;
    int unsigned       cut;
    case ($urandom_range(0, 3))
      0:       g = 3'd0;
      1:       g = 3'd5;
      default: g = 3'd7;
    endcase
    case ($urandom_range(0, 8))
      0: op = 8'h88 | 8'($urandom_range(0, 3));
      1: op = {2'b00, g, 1'b0, 2'($urandom_range(0, 3))};
      2: op = 8'hC6 | 8'($urandom_range(0, 1));
      3: op = 8'h80 | 8'($urandom_range(0, 3));
      4: op = {2'b00, g, 2'b10, 1'($urandom_range(0, 1))};
      5: op = 8'hB0 | 8'($urandom_range(0, 15));
      6: op = 8'hA0 | 8'($urandom_range(0, 3));
      7: begin
        do op = 8'($urandom_range(0, 255));
        while (chk.opcode_kind(op) != x86dec_pkg::KIND_NONE);
      end
      default: op = 8'($urandom_range(0, 255));
    endcase
    k = chk.opcode_kind(op);
    inst.push_back(op);
    case (k)
      x86dec_pkg::KIND_MOVRM, x86dec_pkg::KIND_ARITH,
      x86dec_pkg::KIND_MOVIMM, x86dec_pkg::KIND_GROUP: begin
        modrm[7:6] = 2'($urandom_range(0, 3));
        modrm[5:3] = 3'($urandom_range(0, 7));
        modrm[2:0] = ($urandom_range(0, 3) == 0) ? x86dec_pkg::RmDirect :
                     3'($urandom_range(0, 7));
        // immediate mov mostly with reg field zero
        if (k == x86dec_pkg::KIND_MOVIMM && $urandom_range(0, 3) != 0) modrm[5:3] = 3'd0;
        inst.push_back(modrm);
        extra = chk.disp_len(modrm) + chk.imm_len(k, op);
      end
      x86dec_pkg::KIND_ACCIMM: extra = op[0] ? 2 : 1;
      x86dec_pkg::KIND_REGIMM: extra = op[3] ? 2 : 1;
      x86dec_pkg::KIND_ACCMEM: extra = 2;
      default:                 extra = 0;
    endcase
    repeat (extra) inst.push_back(8'($urandom_range(0, 255)));
    // broken sequence: drop trailing bytes
    if (inst.size() > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, inst.size() - 1);
      repeat (cut) void'(inst.pop_back());
    end
    foreach (inst[i]) code_stream.push_back(inst[i]);
  endtask

  // directed instructions, then random ones
  task automatic build_code_stream();
    logic [7:0] directed_code [$];
    directed_code = '{
      8'h29, 8'h47, 8'h7F,                      // sub, byte displacement 127
      8'h80, 8'h3E, 8'h00, 8'h80, 8'hFF,        // cmp group, direct address
      8'h83, 8'hD0, 8'h80,                      // group entry not handled
      8'hC7, 8'hAE, 8'hFF, 8'hFF, 8'h00, 8'h80, // six bytes, mov reg field 5
      8'h05, 8'hFF, 8'h7F,                      // add to accumulator, word
      8'hBF, 8'h00, 8'h80,                      // word immediate to register
      8'hA3, 8'h00, 8'h00,                      // accumulator to memory
      8'hFF                                     // unknown opcode
    };
    foreach (directed_code[i]) code_stream.push_back(directed_code[i]);
    while (code_stream.size() < StreamBytes) append_instruction();
  endtask

  // sender
  task automatic drive_code_stream();
    int gap;
    foreach (code_stream[idx]) begin
      // pause until the decoder has drained
      if (idx == PauseIndex) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (chk.pending() != 0);
      end
      gap = ((((idx / 80) % 3) == 1) || receiver_holding) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid     <= 1'b1;
      in_code_byte <= code_stream[idx];
      do @(posedge clk); while (in_stall);
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    chk          = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_code_byte = 8'h00;
    build_code_stream();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    drive_code_stream();
    do @(negedge clk); while (chk.pending() != 0);
    repeat (16) @(negedge clk);
    chk.report_leftover();
    if (chk.errors == 0) begin
      $display("PASS x86_16_mov_alu_instruction_decoder");
    end else begin
      $display("FAIL x86_16_mov_alu_instruction_decoder");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off
  initial begin : receiver
    int wait_n;
    out_stall        = 1'b0;
    receiver_holding = 1'b0;
    long_hold_done   = 1'b0;
    @(posedge rst_n);
    forever begin
      if (records_seen >= 100 && !long_hold_done) begin
        long_hold_done   = 1'b1;
        receiver_holding = 1'b1;
        out_stall <= 1'b1;
        repeat (LongHold) @(negedge clk);
        receiver_holding = 1'b0;
      end
      wait_n = (((records_seen / 40) % 3) == 1) ? 0 : $urandom_range(0, 4);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // monitor: input transactions first, then output transactions
  always @(posedge clk) begin
    x86dec_pkg::rec_t got;
    if (rst_n && in_valid && !in_stall) chk.take_code_byte(in_code_byte);
    if (rst_n && out_valid && !out_stall) begin
      got.operation    = out_operation;
      got.form         = out_form;
      got.wide         = out_wide;
      got.to_register  = out_to_register;
      got.mode_field   = out_mode_field;
      got.reg_field    = out_reg_field;
      got.rm_field     = out_rm_field;
      got.displacement = out_displacement;
      got.immediate    = out_immediate;
      got.length       = out_length;
      got.unknown      = out_unknown;
      records_seen++;
      chk.check_record(got);
    end
  end

  initial records_seen = 0;

  // watchdog
  initial begin
    #2000000;
    $display("FAIL x86_16_mov_alu_instruction_decoder");
    $finish;
  end

endmodule
